>>> design/cde_pkg.sv
`default_nettype none

package cde_pkg;

    localparam int KIND_W   = 3;
    localparam int WORD_W   = 32;
    localparam int STATUS_W = 2;

    // operation codes carried by a request
    localparam logic [KIND_W-1:0] KIND_PUSH_FRONT = 3'd0;
    localparam logic [KIND_W-1:0] KIND_PUSH_REAR  = 3'd1;
    localparam logic [KIND_W-1:0] KIND_POP_FRONT  = 3'd2;
    localparam logic [KIND_W-1:0] KIND_POP_REAR   = 3'd3;
    localparam logic [KIND_W-1:0] KIND_DISPLAY    = 3'd4;

    // result status codes
    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

    // controller to datapath
    typedef struct packed {
        logic exec;  // execute the request accepted in this cycle
        logic rd;    // read the store at the walk pointer
        logic emit;  // load the read word into the result register
    } cde_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic walk;        // accepted kind starts a listing walk
        logic last_entry;  // walk is at its final entry
        logic out_free;    // result register can take a new result
    } cde_sts_t;

endpackage

`default_nettype wire

>>> design/cde_if.sv
`default_nettype none

interface cde_req_if
    import cde_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic [KIND_W-1:0]        kind;
    logic signed [WORD_W-1:0] value;

    modport source (output valid, output kind, output value, input ready);
    modport sink   (input valid, input kind, input value, output ready);
endinterface

interface cde_rsp_if
    import cde_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic [STATUS_W-1:0]      status;
    logic signed [WORD_W-1:0] data;
    logic                     last;

    modport source (output valid, output status, output data, output last, input ready);
    modport sink   (input valid, input status, input data, input last, output ready);
endinterface

`default_nettype wire

>>> design/circular_deque_engine.sv
// Push, pop and error requests: result registered in the cycle after acceptance; one request
//   per cycle while the result side keeps taking results.
// Display of N entries: N results, each through the store read port, then the result register;
//   no request is taken until the last result is loaded.
// Reset (rst_n, async, active low) clears head, tail, count, the walk state and the result valid
//   flag; the store itself is not cleared, as only entries written by a push are ever read.
`default_nettype none

module circular_deque_engine
    import cde_pkg::*;
#(
    parameter int DEPTH = 16
)
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    cde_req_if.sink    req,
    cde_rsp_if.source  rsp
);

    localparam int CNT_W = $clog2(DEPTH + 1);

    cde_cmd_t         cmd;
    cde_sts_t         sts;
    logic [CNT_W-1:0] count;
    logic             in_ready;

    // Controller: sequences the listing walk and gates request acceptance.
    cde_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req.valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // Datapath: store, head/tail/count pointers, walk pointer and result register.
    cde_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .kind       (req.kind),
        .value      (req.value),
        .sts        (sts),
        .count      (count),
        .out_valid  (rsp.valid),
        .out_status (rsp.status),
        .out_data   (rsp.data),
        .out_last   (rsp.last),
        .out_ready  (rsp.ready)
    );

    assign req.ready = in_ready;

    // Occupancy never exceeds the store size.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count <= CNT_W'(DEPTH))
        else $error("deque count exceeds depth");

    // Occupancy moves only when a request is accepted.
    a_count_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !(req.valid && req.ready) |=> $stable(count))
        else $error("deque count changed without a request");

    // A non-final result only occurs mid-listing, when no request may enter.
    a_walk_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && !rsp.last) |-> !req.ready)
        else $error("request accepted during a listing walk");

    // Error results always close their request.
    a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && (rsp.status != STATUS_OK)) |-> rsp.last)
        else $error("error result not marked last");

endmodule

`default_nettype wire

>>> design/cde_ctrl.sv
`default_nettype none

module cde_ctrl
    import cde_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     in_valid,
    output logic          in_ready,
    input  wire cde_sts_t sts,
    output cde_cmd_t      cmd
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_READ = 2'd1;
    localparam logic [1:0] ST_LOAD = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic       accept;

    assign in_ready = (state_reg == ST_IDLE) && sts.out_free;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                cmd.exec = accept;
                if (accept && sts.walk)
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                cmd.rd     = 1'b1;
                state_next = ST_LOAD;
            end
            ST_LOAD:
            begin
                if (sts.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = sts.last_entry ? ST_IDLE : ST_READ;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

>>> design/cde_dp.sv
`default_nettype none

module cde_dp
    import cde_pkg::*;
#(
    parameter int DEPTH = 16
)
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire cde_cmd_t                 cmd,
    input  wire logic [KIND_W-1:0]        kind,
    input  wire logic signed [WORD_W-1:0] value,
    output cde_sts_t                      sts,
    output logic [$clog2(DEPTH+1)-1:0]    count,
    output logic                          out_valid,
    output logic [STATUS_W-1:0]           out_status,
    output logic signed [WORD_W-1:0]      out_data,
    output logic                          out_last,
    input  wire logic                     out_ready
);

    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [IDX_W-1:0] IDX_MAX = IDX_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);
    localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);

    logic signed [WORD_W-1:0] mem [DEPTH];

    logic [IDX_W-1:0] head_reg, head_next;
    logic [IDX_W-1:0] tail_reg, tail_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [IDX_W-1:0] rd_idx_reg, rd_idx_next;
    logic [CNT_W-1:0] rem_reg, rem_next;
    logic signed [WORD_W-1:0] rd_data_reg;

    logic                     out_valid_reg, out_valid_next;
    logic [STATUS_W-1:0]      out_status_reg, out_status_next;
    logic signed [WORD_W-1:0] out_data_reg, out_data_next;
    logic                     out_last_reg, out_last_next;

    logic             mem_we;
    logic [IDX_W-1:0] mem_waddr;
    logic             empty;
    logic             full;

    function automatic logic [IDX_W-1:0] wrap_inc(input logic [IDX_W-1:0] i);
        return (i == IDX_MAX) ? '0 : i + IDX_W'(1);
    endfunction

    function automatic logic [IDX_W-1:0] wrap_dec(input logic [IDX_W-1:0] i);
        return (i == '0) ? IDX_MAX : i - IDX_W'(1);
    endfunction

    assign empty = (count_reg == '0);
    assign full  = (count_reg == CNT_FULL);

    assign sts.walk       = (kind == KIND_DISPLAY) && !empty;
    assign sts.last_entry = (rem_reg == CNT_ONE);
    assign sts.out_free   = !out_valid_reg || out_ready;

    always_comb
    begin
        head_next       = head_reg;
        tail_next       = tail_reg;
        count_next      = count_reg;
        rd_idx_next     = rd_idx_reg;
        rem_next        = rem_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        out_status_next = out_status_reg;
        out_data_next   = out_data_reg;
        out_last_next   = out_last_reg;
        mem_we          = 1'b0;
        mem_waddr       = '0;

        if (cmd.exec)
        begin
            if (kind inside {KIND_PUSH_FRONT, KIND_PUSH_REAR})
            begin
                out_valid_next  = 1'b1;
                out_data_next   = '0;
                out_last_next   = 1'b1;
                out_status_next = full ? STATUS_FULL : STATUS_OK;
                if (!full)
                begin
                    mem_we     = 1'b1;
                    count_next = count_reg + CNT_ONE;
                    if (empty)
                    begin
                        head_next = '0;
                        tail_next = '0;
                        mem_waddr = '0;
                    end
                    else if (kind == KIND_PUSH_FRONT)
                    begin
                        head_next = wrap_dec(head_reg);
                        mem_waddr = head_next;
                    end
                    else
                    begin
                        tail_next = wrap_inc(tail_reg);
                        mem_waddr = tail_next;
                    end
                end
            end
            else if (kind inside {KIND_POP_FRONT, KIND_POP_REAR})
            begin
                out_valid_next  = 1'b1;
                out_data_next   = '0;
                out_last_next   = 1'b1;
                out_status_next = empty ? STATUS_EMPTY : STATUS_OK;
                if (!empty)
                begin
                    count_next = count_reg - CNT_ONE;
                    if (count_reg == CNT_ONE)
                    begin
                        head_next = '0;
                        tail_next = '0;
                    end
                    else if (kind == KIND_POP_FRONT)
                    begin
                        head_next = wrap_inc(head_reg);
                    end
                    else
                    begin
                        tail_next = wrap_dec(tail_reg);
                    end
                end
            end
            else if (kind == KIND_DISPLAY)
            begin
                if (empty)
                begin
                    out_valid_next  = 1'b1;
                    out_data_next   = '0;
                    out_last_next   = 1'b1;
                    out_status_next = STATUS_EMPTY;
                end
                else
                begin
                    rd_idx_next = head_reg;
                    rem_next    = count_reg;
                end
            end
        end

        if (cmd.emit)
        begin
            out_valid_next  = 1'b1;
            out_status_next = STATUS_OK;
            out_data_next   = rd_data_reg;
            out_last_next   = (rem_reg == CNT_ONE);
            rd_idx_next     = wrap_inc(rd_idx_reg);
            rem_next        = rem_reg - CNT_ONE;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= value;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.rd)
        begin
            rd_data_reg <= mem[rd_idx_reg];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg      <= '0;
            tail_reg      <= '0;
            count_reg     <= '0;
            rd_idx_reg    <= '0;
            rem_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            count_reg     <= count_next;
            rd_idx_reg    <= rd_idx_next;
            rem_reg       <= rem_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_status_reg <= out_status_next;
        out_data_reg   <= out_data_next;
        out_last_reg   <= out_last_next;
    end

    assign count      = count_reg;
    assign out_valid  = out_valid_reg;
    assign out_status = out_status_reg;
    assign out_data   = out_data_reg;
    assign out_last   = out_last_reg;

endmodule

`default_nettype wire

>>> tb/sv/deque_checker.sv
module deque_checker
    import cde_pkg::*;
#(
    parameter int DEPTH = 16
)
(
    input  logic clk,
    input  logic rst_n,
    cde_req_if   req,
    cde_rsp_if   rsp,
    output int   mismatches,
    output int   results_owed
);

    localparam int IDX_W = $clog2(DEPTH);

    typedef struct packed {
        logic [STATUS_W-1:0]      status;
        logic signed [WORD_W-1:0] data;
        logic                     last;
    } deque_result_t;

    logic signed [WORD_W-1:0] shadow_store [DEPTH];
    logic [IDX_W-1:0]         front_idx;
    logic [IDX_W-1:0]         rear_idx;
    logic [IDX_W:0]           fill_level;
    deque_result_t            owed_results [$];
    deque_result_t            seen;
    deque_result_t            wanted;

    function automatic logic [IDX_W-1:0] step_up(input logic [IDX_W-1:0] i);
        return (i == IDX_W'(DEPTH - 1)) ? '0 : i + 1'b1;
    endfunction

    function automatic logic [IDX_W-1:0] step_down(input logic [IDX_W-1:0] i);
        return (i == '0) ? IDX_W'(DEPTH - 1) : i - 1'b1;
    endfunction

    // single-result acknowledge: no data, marked last
    function automatic deque_result_t ack(input logic [STATUS_W-1:0] status);
        deque_result_t r;
        r.status = status;
        r.data   = '0;
        r.last   = 1'b1;
        return r;
    endfunction

    task automatic apply_request(input logic [KIND_W-1:0] kind,
                                 input logic signed [WORD_W-1:0] word);
        logic [IDX_W-1:0] walk;
        deque_result_t    r;
        case (kind)
            KIND_PUSH_FRONT, KIND_PUSH_REAR:
            begin
                if (fill_level == (IDX_W + 1)'(DEPTH))
                begin
                    owed_results.push_back(ack(STATUS_FULL));
                end
                else
                begin
                    if (fill_level == '0)
                    begin
                        front_idx = '0;
                        rear_idx  = '0;
                    end
                    else if (kind == KIND_PUSH_FRONT)
                    begin
                        front_idx = step_down(front_idx);
                    end
                    else
                    begin
                        rear_idx = step_up(rear_idx);
                    end
                    shadow_store[(kind == KIND_PUSH_FRONT) ? front_idx : rear_idx] = word;
                    fill_level = fill_level + 1'b1;
                    owed_results.push_back(ack(STATUS_OK));
                end
            end
            KIND_POP_FRONT, KIND_POP_REAR:
            begin
                if (fill_level == '0)
                begin
                    owed_results.push_back(ack(STATUS_EMPTY));
                end
                else
                begin
                    if (fill_level == 1)
                    begin
                        front_idx = '0;
                        rear_idx  = '0;
                    end
                    else if (kind == KIND_POP_FRONT)
                    begin
                        front_idx = step_up(front_idx);
                    end
                    else
                    begin
                        rear_idx = step_down(rear_idx);
                    end
                    fill_level = fill_level - 1'b1;
                    owed_results.push_back(ack(STATUS_OK));
                end
            end
            KIND_DISPLAY:
            begin
                if (fill_level == '0)
                begin
                    owed_results.push_back(ack(STATUS_EMPTY));
                end
                else
                begin
                    // list front to rear, mark the final entry
                    walk = front_idx;
                    for (int n = 0; n < fill_level; n++)
                    begin
                        r.status = STATUS_OK;
                        r.data   = shadow_store[walk];
                        r.last   = (n == fill_level - 1);
                        owed_results.push_back(r);
                        walk = step_up(walk);
                    end
                end
            end
            default:
            begin
                // undefined codes: no result, no state change
            end
        endcase
    endtask

    task automatic note_mismatch(input string what, input deque_result_t exp_r,
                                 input deque_result_t got_r);
        mismatches++;
        if (mismatches <= 10)
        begin
            $display("%0t: deque result %s: expected status %0d data %0d last %0b,",
                     $time, what, exp_r.status, exp_r.data, exp_r.last);
            $display("    got status %0d data %0d last %0b",
                     got_r.status, got_r.data, got_r.last);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_idx    = '0;
            rear_idx     = '0;
            fill_level   = '0;
            mismatches   = 0;
            results_owed = 0;
            owed_results.delete();
        end
        else
        begin
            // results never leave in the cycle their request is taken, so check first
            if (rsp.valid && rsp.ready)
            begin
                seen.status = rsp.status;
                seen.data   = rsp.data;
                seen.last   = rsp.last;
                if (owed_results.size() == 0)
                begin
                    note_mismatch("with nothing owed", ack(STATUS_OK), seen);
                end
                else
                begin
                    wanted = owed_results.pop_front();
                    if (seen !== wanted)
                        note_mismatch("mismatch", wanted, seen);
                end
            end
            if (req.valid && req.ready)
                apply_request(req.kind, req.value);
            results_owed = owed_results.size();
        end
    end

endmodule

>>> tb/sv/testbench.sv
module testbench;
    import cde_pkg::*;

    localparam int DEPTH           = 16;
    localparam int REQUEST_TARGET  = 220;
    // worst case: every request a full listing, each result waiting out a slow
    // receiver, plus gaps and the long hold-off; then several times over
    localparam int CYCLE_LIMIT     = 2000000;
    localparam int HOLD_OFF_CYCLES = 160;
    // a full listing reads each entry through the store, then the result register
    localparam int SETTLE_CYCLES   = 4 * DEPTH;

    typedef enum int {FILL_UP, DRAIN_DOWN, CHURN} phase_mode_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;
    int   cycle_count    = 0;
    int   requests_sent  = 0;
    int   hold_off_asked = 0;
    int   burst_left     = 0;
    bit   steady         = 1'b0;
    int   mismatches;
    int   results_owed;

    cde_req_if req_ch ();
    cde_rsp_if rsp_ch ();

    circular_deque_engine #(.DEPTH(DEPTH)) dut
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch.sink),
        .rsp   (rsp_ch.source)
    );

    // watches both channels, predicts every result and compares
    deque_checker #(.DEPTH(DEPTH)) checker_inst
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .req          (req_ch),
        .rsp          (rsp_ch),
        .mismatches   (mismatches),
        .results_owed (results_owed)
    );

    always #10 clk = ~clk;

    // abort a hung run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Offer one request at the falling edge and hold it until the block takes it.
    // Bursts: keep valid high across a burst; drop it for a random gap at the end
    // of a burst unless the current stretch runs without idling.
    task automatic offer(input logic [KIND_W-1:0] kind,
                         input logic signed [WORD_W-1:0] word);
        int gap;
        @(negedge clk);
        req_ch.valid <= 1'b1;
        req_ch.kind  <= kind;
        req_ch.value <= word;
        do
        begin
            @(posedge clk);
        end
        while (!req_ch.ready);
        if (kind <= KIND_DISPLAY)
            requests_sent++;
        if (burst_left > 0)
        begin
            burst_left--;
        end
        else
        begin
            burst_left = $urandom_range(1, 12);
            if (!steady)
            begin
                gap = $urandom_range(1, 6);
                @(negedge clk);
                req_ch.valid <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
        end
    endtask

    // Stop offering and hold until every owed result has come back.
    task automatic drain_results();
        @(negedge clk);
        req_ch.valid <= 1'b0;
        while (results_owed != 0)
            @(negedge clk);
    endtask

    // Mix the word extremes in with fully random words.
    function automatic logic signed [WORD_W-1:0] random_word();
        case ($urandom_range(0, 7))
            0:       return {1'b1, {(WORD_W - 1){1'b0}}};
            1:       return {1'b0, {(WORD_W - 1){1'b1}}};
            2:       return '1;
            3:       return '0;
            default: return $urandom;
        endcase
    endfunction

    // Pick an operation biased by the phase: fill toward full, drain toward
    // empty, or churn evenly. A few undefined codes slip in as noise.
    function automatic logic [KIND_W-1:0] pick_kind(input phase_mode_t mode);
        int  roll;
        bit  push;
        bit  at_front;
        roll     = $urandom_range(0, 99);
        at_front = 1'($urandom_range(0, 1));
        if (roll < 3)
            return KIND_DISPLAY + KIND_W'($urandom_range(1, 3));
        if (roll < 15)
            return KIND_DISPLAY;
        case (mode)
            FILL_UP:    push = (roll < 85);
            DRAIN_DOWN: push = (roll >= 85);
            default:    push = (roll < 57);
        endcase
        if (push)
            return at_front ? KIND_PUSH_FRONT : KIND_PUSH_REAR;
        return at_front ? KIND_POP_FRONT : KIND_POP_REAR;
    endfunction

    // Receiver: take results on a pattern of its own, picking a new one after each
    // random span. When the stimulus asks, starve the output for a long stretch.
    initial
    begin : result_taker
        int         mode;
        int         span;
        int         hold_off_served;
        logic [7:0] mask;
        hold_off_served = 0;
        rsp_ch.ready    = 1'b0;
        forever
        begin
            mode = $urandom_range(0, 3);
            span = $urandom_range(8, 60);
            mask = 8'($urandom);
            for (int c = 0; c < span; c++)
            begin
                @(negedge clk);
                if (hold_off_asked != hold_off_served)
                begin
                    hold_off_served = hold_off_asked;
                    rsp_ch.ready <= 1'b0;
                    repeat (HOLD_OFF_CYCLES) @(negedge clk);
                end
                case (mode)
                    0:       rsp_ch.ready <= 1'b1;
                    1:       rsp_ch.ready <= 1'($urandom_range(0, 1));
                    2:       rsp_ch.ready <= mask[c[2:0]];
                    default: rsp_ch.ready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    // Sender: directed opening, then phased random traffic, then the verdict.
    initial
    begin : request_maker
        phase_mode_t mode;
        int          span;
        int          phase;
        req_ch.valid = 1'b0;
        req_ch.kind  = KIND_PUSH_FRONT;
        req_ch.value = '0;

        // hold reset, then release it away from the rising edge
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // errors on an empty deque
        offer(KIND_DISPLAY,    random_word());
        offer(KIND_POP_FRONT,  random_word());
        offer(KIND_POP_REAR,   random_word());
        // push onto empty, then both ends with the word extremes
        offer(KIND_PUSH_FRONT, {1'b0, {(WORD_W - 1){1'b1}}});
        offer(KIND_PUSH_REAR,  {1'b1, {(WORD_W - 1){1'b0}}});
        offer(KIND_PUSH_FRONT, '1);
        offer(KIND_PUSH_REAR,  '0);
        offer(KIND_DISPLAY,    random_word());
        offer(KIND_POP_FRONT,  random_word());
        offer(KIND_POP_REAR,   random_word());
        offer(KIND_DISPLAY,    random_word());
        // pop down to one entry, then pop the only entry
        offer(KIND_POP_FRONT,  random_word());
        offer(KIND_POP_REAR,   random_word());
        // undefined codes are dropped without a result
        offer(KIND_DISPLAY + 3'd1, random_word());
        offer(KIND_DISPLAY + 3'd2, random_word());
        offer(KIND_DISPLAY + 3'd3, random_word());
        // push at the rear onto empty, then wrap the head back past index zero
        offer(KIND_PUSH_REAR,  random_word());
        offer(KIND_PUSH_FRONT, random_word());
        offer(KIND_PUSH_FRONT, random_word());
        offer(KIND_DISPLAY,    random_word());
        offer(KIND_POP_REAR,   random_word());
        offer(KIND_POP_REAR,   random_word());
        offer(KIND_POP_REAR,   random_word());
        drain_results();

        phase = 0;
        while (requests_sent < REQUEST_TARGET)
        begin
            mode   = phase_mode_t'($urandom_range(0, 2));
            steady = ($urandom_range(0, 3) == 0);
            span   = $urandom_range(8, 28);
            if (phase == 2)
            begin
                // back the block up: stall the receiver and keep filling nonstop
                mode   = FILL_UP;
                steady = 1'b1;
                span   = 40;
                hold_off_asked++;
            end
            for (int n = 0; n < span; n++)
                offer(pick_kind(mode), random_word());
            // pause now and then until every owed result is back
            if (phase == 4 || $urandom_range(0, 3) == 0)
                drain_results();
            phase++;
        end

        drain_results();
        repeat (SETTLE_CYCLES) @(negedge clk);
        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

>>> circular_deque_engine.f
design/cde_pkg.sv
design/cde_if.sv
design/cde_ctrl.sv
design/cde_dp.sv
design/circular_deque_engine.sv
tb/sv/deque_checker.sv
tb/sv/testbench.sv
